// ===== hdl/assert_macros.svh =====
// Assertion macros used by the top level RTL file of the sorted key table.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold on every clock edge out of reset.
`define ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent implies consequent in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/stkt_pkg.sv =====
// Package: sizes, operation and status codes, compare result type for the sorted key table.
`timescale 1ns / 1ps

package stkt_pkg;

    localparam int CAPACITY     = 16;
    localparam int KEY_BITS     = 16;
    localparam int PAYLOAD_BITS = 32;

    localparam int IDX_BITS   = $clog2(CAPACITY);
    localparam int CNT_BITS   = $clog2(CAPACITY + 1);
    localparam int ENTRY_BITS = KEY_BITS + PAYLOAD_BITS;

    typedef enum logic [1:0] {
        OP_INSERT = 2'd0,
        OP_LOOKUP = 2'd1,
        OP_REMOVE = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_NOT_FOUND = 2'd2
    } status_t;

    // Result of the shared key comparator: stored key versus probe key.
    typedef struct packed {
        logic eq;
        logic gt;
    } cmp_res_t;

endpackage

// ===== hdl/stkt_ram.sv =====
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps

module stkt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/stkt_cmp.sv =====
// Shared key comparator: equality and greater-than of a stored key against the probe key.
`timescale 1ns / 1ps

module stkt_cmp (
    input  logic [stkt_pkg::KEY_BITS-1:0] stored_key,
    input  logic [stkt_pkg::KEY_BITS-1:0] probe_key,
    output stkt_pkg::cmp_res_t            res
);

    always_comb
    begin
        res.eq = (stored_key == probe_key);
        res.gt = (stored_key > probe_key);
    end

endmodule

// ===== hdl/sorted_key_table_unit.sv =====
// Top level of the sorted key table: sequencer, entry RAM, comparator and result register.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one transaction: operation, key, payload.
//   Output channel (out_valid / out_stall) returns one transaction per input: status,
//   found, found_payload, entry_count, is_empty.
//   Entries live in one RAM (key and payload side by side, packed in ascending order at
//   positions 0 .. count-1). One comparator is reused for every stored key.
//   Each scanned entry takes a RAM read, then a compare; each moved entry a read, then a
//   write. Clear and insert-into-full go straight to the result; lookup stops at the first
//   hit, while a miss scans all entries; insert scans, then opens a gap from the top; remove
//   scans, then closes the hole. out_valid rises in the same cycle that the next
//   transaction can be taken. Entries are handled one at a time, as there is a single RAM
//   read port and a single comparator.
//   in_stall is high from acceptance until the result is loaded into the output register.
//   A finished result waits in the output register while the next transaction is taken;
//   if the receiver still stalls when the next result is ready, the sequencer holds it
//   until the output register frees.
//   Reset (rst_n low, asynchronous) empties the table and drops out_valid; RAM contents
//   are left as they are and are only read below the entry count.
`timescale 1ns / 1ps

module sorted_key_table_unit (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  operation,
    input  logic [15:0] key,
    input  logic [31:0] payload,

    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  status,
    output logic        found,
    output logic [31:0] found_payload,
    output logic [4:0]  entry_count,
    output logic        is_empty
);

    localparam int KB = stkt_pkg::KEY_BITS;
    localparam int PB = stkt_pkg::PAYLOAD_BITS;
    localparam int IB = stkt_pkg::IDX_BITS;
    localparam int CB = stkt_pkg::CNT_BITS;
    localparam int EB = stkt_pkg::ENTRY_BITS;
    localparam logic [CB-1:0] CAP_CNT = CB'(stkt_pkg::CAPACITY);

    typedef enum logic [6:0] {
        S_IDLE     = 7'b0000001,
        S_SCAN_RD  = 7'b0000010,
        S_SCAN_CMP = 7'b0000100,
        S_SHIFT_RD = 7'b0001000,
        S_SHIFT_WR = 7'b0010000,
        S_PUT      = 7'b0100000,
        S_DONE     = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [CB-1:0] count_reg, count_next;
    logic [CB-1:0] pos_reg, pos_next;   // scan position / insert target
    logic [CB-1:0] cur_reg, cur_next;   // slot being moved into

    stkt_pkg::op_t     op_reg, op_next;
    logic [KB-1:0]     key_reg, key_next;
    logic [PB-1:0]     pay_reg, pay_next;

    stkt_pkg::status_t status_reg, status_next;
    logic              found_reg, found_next;
    logic [PB-1:0]     fpay_reg, fpay_next;

    // output register
    logic              out_valid_reg, out_valid_next;
    stkt_pkg::status_t out_status_reg, out_status_next;
    logic              out_found_reg, out_found_next;
    logic [PB-1:0]     out_fpay_reg, out_fpay_next;
    logic [CB-1:0]     out_count_reg, out_count_next;

    // entry RAM
    logic          ram_wr_en;
    logic [IB-1:0] ram_wr_addr;
    logic [EB-1:0] ram_wr_data;
    logic          ram_rd_en;
    logic [IB-1:0] ram_rd_addr;
    logic [EB-1:0] ram_rd_data;

    logic [KB-1:0] rd_key;
    logic [PB-1:0] rd_pay;
    logic [CB-1:0] pos_inc;
    logic [CB-1:0] cur_inc;
    logic [CB-1:0] cur_dec;

    stkt_pkg::cmp_res_t cmp_res;

    stkt_ram #(
        .WIDTH (EB),
        .DEPTH (stkt_pkg::CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_key = ram_rd_data[EB-1:PB];
    assign rd_pay = ram_rd_data[PB-1:0];

    stkt_cmp u_cmp (
        .stored_key (rd_key),
        .probe_key  (key_reg),
        .res        (cmp_res)
    );

    // pos and cur stay within 0 .. count, so these never wrap
    assign pos_inc = pos_reg + CB'(1);
    assign cur_inc = cur_reg + CB'(1);
    assign cur_dec = cur_reg - CB'(1);

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        pos_next        = pos_reg;
        cur_next        = cur_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        pay_next        = pay_reg;
        status_next     = status_reg;
        found_next      = found_reg;
        fpay_next       = fpay_reg;
        out_valid_next  = out_valid_reg & out_stall;
        out_status_next = out_status_reg;
        out_found_next  = out_found_reg;
        out_fpay_next   = out_fpay_reg;
        out_count_next  = out_count_reg;
        ram_wr_en       = 1'b0;
        ram_wr_addr     = cur_reg[IB-1:0];
        ram_wr_data     = ram_rd_data;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = pos_reg[IB-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next     = stkt_pkg::op_t'(operation);
                    key_next    = KB'(key);
                    pay_next    = PB'(payload);
                    status_next = stkt_pkg::ST_OK;
                    found_next  = 1'b0;
                    fpay_next   = '0;
                    pos_next    = '0;
                    case (stkt_pkg::op_t'(operation))
                        stkt_pkg::OP_CLEAR:
                        begin
                            count_next = '0;
                            state_next = S_DONE;
                        end
                        stkt_pkg::OP_INSERT:
                        begin
                            if (count_reg == CAP_CNT)
                            begin
                                status_next = stkt_pkg::ST_FULL;
                                state_next  = S_DONE;
                            end
                            else
                            begin
                                state_next = S_SCAN_RD;
                            end
                        end
                        default:
                        begin
                            state_next = S_SCAN_RD;
                        end
                    endcase
                end
            end

            S_SCAN_RD:
            begin
                if (pos_reg == count_reg)
                begin
                    // ran off the end of the table
                    if (op_reg == stkt_pkg::OP_INSERT)
                    begin
                        cur_next   = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        status_next = stkt_pkg::ST_NOT_FOUND;
                        state_next  = S_DONE;
                    end
                end
                else
                begin
                    ram_rd_en   = 1'b1;
                    ram_rd_addr = pos_reg[IB-1:0];
                    state_next  = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (op_reg == stkt_pkg::OP_INSERT)
                begin
                    if (cmp_res.gt)
                    begin
                        cur_next   = count_reg;
                        state_next = S_SHIFT_RD;
                    end
                    else
                    begin
                        pos_next   = pos_inc;
                        state_next = S_SCAN_RD;
                    end
                end
                else if (cmp_res.eq)
                begin
                    found_next = 1'b1;
                    if (op_reg == stkt_pkg::OP_LOOKUP)
                    begin
                        fpay_next  = rd_pay;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cur_next   = pos_reg;
                        state_next = S_SHIFT_RD;
                    end
                end
                else
                begin
                    pos_next   = pos_inc;
                    state_next = S_SCAN_RD;
                end
            end

            S_SHIFT_RD:
            begin
                if (op_reg == stkt_pkg::OP_INSERT)
                begin
                    // open a gap at pos, moving entries up from the top
                    if (cur_reg == pos_reg)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_dec[IB-1:0];
                        state_next  = S_SHIFT_WR;
                    end
                end
                else
                begin
                    // close the hole left by the removed entry
                    if (cur_inc >= count_reg)
                    begin
                        count_next = count_reg - CB'(1);
                        state_next = S_DONE;
                    end
                    else
                    begin
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = cur_inc[IB-1:0];
                        state_next  = S_SHIFT_WR;
                    end
                end
            end

            S_SHIFT_WR:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = cur_reg[IB-1:0];
                ram_wr_data = ram_rd_data;
                if (op_reg == stkt_pkg::OP_INSERT)
                begin
                    cur_next = cur_dec;
                end
                else
                begin
                    cur_next = cur_inc;
                end
                state_next = S_SHIFT_RD;
            end

            S_PUT:
            begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = pos_reg[IB-1:0];
                ram_wr_data = {key_reg, pay_reg};
                count_next  = count_reg + CB'(1);
                state_next  = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_found_next  = found_reg;
                    out_fpay_next   = fpay_reg;
                    out_count_next  = count_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg        <= pos_next;
        cur_reg        <= cur_next;
        op_reg         <= op_next;
        key_reg        <= key_next;
        pay_reg        <= pay_next;
        status_reg     <= status_next;
        found_reg      <= found_next;
        fpay_reg       <= fpay_next;
        out_status_reg <= out_status_next;
        out_found_reg  <= out_found_next;
        out_fpay_reg   <= out_fpay_next;
        out_count_reg  <= out_count_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign found         = out_found_reg;
    assign found_payload = 32'(out_fpay_reg);
    assign entry_count   = 5'(out_count_reg);
    assign is_empty      = (out_count_reg == '0);

`include "assert_macros.svh"

    `ASSERT_ALWAYS(a_count_bound, count_reg <= CAP_CNT, "entry count above capacity")

    `ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall,
        "sequencer not busy after accepting a transaction")

    `ASSERT_SAME(a_full_means_full, out_valid && status == stkt_pkg::ST_FULL,
        entry_count == 5'(CAP_CNT), "full status with a table that is not full")

    `ASSERT_SAME(a_found_ok, out_valid && found, status == stkt_pkg::ST_OK,
        "found flag with a non-ok status")

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the sorted key table: directed table, then weighted random traffic.
`timescale 1ns / 1ps

module testbench;
    import stkt_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 11;
    localparam int RAND_ITEMS   = 1500;
    // The longest operation is a scan plus shift that together cover every stored entry.
    localparam int DRAIN_CYCLES = 4 * CAPACITY + 16;
    localparam int STALL_LIMIT  = 2000;
    localparam int MAX_REPORTS  = 10;
    localparam int IDLE_PCT     = 17;
    localparam int DIR_ROWS     = 26;

    // One result transaction, as the block reports it.
    typedef struct packed {
        status_t                 status;
        logic                    found;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [CNT_BITS-1:0]     count;
        logic                    empty;
    } table_result_t;

    // One row of the directed table. typed = 1 means want holds the answer written by hand;
    // otherwise the table shadow supplies it.
    typedef struct packed {
        op_t                     op;
        logic [KEY_BITS-1:0]     key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    typed;
        table_result_t           want;
    } table_step_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic [1:0]              operation = OP_CLEAR;
    logic [KEY_BITS-1:0]     key = '0;
    logic [PAYLOAD_BITS-1:0] payload = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic [1:0]              status;
    logic                    found;
    logic [PAYLOAD_BITS-1:0] found_payload;
    logic [CNT_BITS-1:0]     entry_count;
    logic                    is_empty;

    sorted_key_table_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .operation     (operation),
        .key           (key),
        .payload       (payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .status        (status),
        .found         (found),
        .found_payload (found_payload),
        .entry_count   (entry_count),
        .is_empty      (is_empty)
    );

    initial
    begin
        forever #CLK_HALF clk = ~clk;
    end

    // Shadow copy of the table contents, kept packed and sorted like the block's RAM.
    logic [KEY_BITS-1:0]     shadow_keys [CAPACITY];
    logic [PAYLOAD_BITS-1:0] shadow_pays [CAPACITY];
    int                      shadow_count = 0;

    table_result_t pending_results [$];
    int            mismatches = 0;
    int            results_checked = 0;
    int            op_tally [4] = '{0, 0, 0, 0};
    int            full_rejects = 0;
    int            key_hits = 0;
    int            dead_cycles = 0;
    bit            burst_mode = 1'b0;    // no idling on either side while set

    // Applies one operation to the shadow table and returns what the block must report.
    function automatic table_result_t apply_to_table(op_t op, logic [KEY_BITS-1:0] k,
                                                     logic [PAYLOAD_BITS-1:0] p);
        table_result_t r;
        int            pos;
        int            i;
        r = '{status: ST_OK, found: 1'b0, payload: '0, count: '0, empty: 1'b0};
        case (op)
            OP_INSERT:
            begin
                if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                begin
                    // new entry goes after any equal keys
                    pos = 0;
                    while (pos < shadow_count && shadow_keys[pos] <= k)
                        pos++;
                    for (i = shadow_count; i > pos; i--)
                    begin
                        shadow_keys[i] = shadow_keys[i-1];
                        shadow_pays[i] = shadow_pays[i-1];
                    end
                    shadow_keys[pos] = k;
                    shadow_pays[pos] = p;
                    shadow_count++;
                end
            end
            OP_LOOKUP, OP_REMOVE:
            begin
                pos = 0;
                while (pos < shadow_count && shadow_keys[pos] != k)
                    pos++;
                if (pos == shadow_count)
                    r.status = ST_NOT_FOUND;
                else
                begin
                    r.found = 1'b1;
                    if (op == OP_LOOKUP)
                        r.payload = shadow_pays[pos];
                    else
                    begin
                        for (i = pos; i + 1 < shadow_count; i++)
                        begin
                            shadow_keys[i] = shadow_keys[i+1];
                            shadow_pays[i] = shadow_pays[i+1];
                        end
                        shadow_count--;
                    end
                end
            end
            default:
                shadow_count = 0;
        endcase
        r.count = CNT_BITS'(shadow_count);
        r.empty = (shadow_count == 0);
        return r;
    endfunction

    // Presents one transaction, holds it until taken, then records what must come back.
    task automatic send_item(op_t op, logic [KEY_BITS-1:0] k, logic [PAYLOAD_BITS-1:0] p,
                             logic typed, table_result_t want);
        table_result_t predicted;
        while (!burst_mode && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        operation <= op;
        key       <= k;
        payload   <= p;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        predicted = apply_to_table(op, k, p);
        pending_results.push_back(typed ? want : predicted);
        op_tally[op]++;
        if (predicted.status == ST_FULL)
            full_rejects++;
        if (predicted.found)
            key_hits++;
    endtask

    // Directed part: empty-table misses, key and payload extremes, duplicate keys,
    // first-match lookup and remove, fill to capacity, insert into a full table, clear.
    table_step_t directed_steps [DIR_ROWS] = '{
        '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0, 5'd0, 1'b1}},
        '{OP_REMOVE, 16'h1234, 32'h0000_0000, 1'b1, '{ST_NOT_FOUND, 1'b0, 32'h0, 5'd0, 1'b1}},
        '{OP_INSERT, 16'hFFFF, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b0, 32'h0, 5'd1, 1'b0}},
        '{OP_INSERT, 16'h0000, 32'h0000_0000, 1'b1, '{ST_OK, 1'b0, 32'h0, 5'd2, 1'b0}},
        '{OP_INSERT, 16'h0000, 32'hA5A5_A5A5, 1'b1, '{ST_OK, 1'b0, 32'h0, 5'd3, 1'b0}},
        '{OP_LOOKUP, 16'h0000, 32'hFFFF_FFFF, 1'b1, '{ST_OK, 1'b1, 32'h0, 5'd3, 1'b0}},
        '{OP_LOOKUP, 16'hFFFF, 32'h0000_0000, 1'b1, '{ST_OK, 1'b1, 32'hFFFF_FFFF, 5'd3, 1'b0}},
        '{OP_REMOVE, 16'h0000, 32'h0000_0000, 1'b1, '{ST_OK, 1'b1, 32'h0, 5'd2, 1'b0}},
        '{OP_LOOKUP, 16'h0000, 32'h0000_0000, 1'b1, '{ST_OK, 1'b1, 32'hA5A5_A5A5, 5'd2, 1'b0}},
        '{OP_INSERT, 16'h8000, 32'h5A5A_5A5A, 1'b0, '0},
        '{OP_INSERT, 16'h7FFF, 32'h0000_0001, 1'b0, '0},
        '{OP_INSERT, 16'h0001, 32'h8000_0000, 1'b0, '0},
        '{OP_INSERT, 16'hFFFE, 32'h7FFF_FFFF, 1'b0, '0},
        '{OP_INSERT, 16'h1234, 32'h1234_5678, 1'b0, '0},
        '{OP_INSERT, 16'h8000, 32'hDEAD_0001, 1'b0, '0},
        '{OP_INSERT, 16'h4321, 32'h0F0F_0F0F, 1'b0, '0},
        '{OP_INSERT, 16'h0F0F, 32'hF0F0_F0F0, 1'b0, '0},
        '{OP_INSERT, 16'hF0F0, 32'h3333_3333, 1'b0, '0},
        '{OP_INSERT, 16'h00FF, 32'hCCCC_CCCC, 1'b0, '0},
        '{OP_INSERT, 16'hFF00, 32'h5555_5555, 1'b0, '0},
        '{OP_INSERT, 16'h5555, 32'hAAAA_AAAA, 1'b0, '0},
        '{OP_INSERT, 16'hAAAA, 32'h0000_FFFF, 1'b0, '0},
        '{OP_INSERT, 16'h0002, 32'hFFFF_0000, 1'b0, '0},
        '{OP_INSERT, 16'h3333, 32'h1111_1111, 1'b1, '{ST_FULL, 1'b0, 32'h0, 5'd16, 1'b0}},
        '{OP_REMOVE, 16'hFFFF, 32'h0000_0000, 1'b0, '0},
        '{OP_CLEAR,  16'h0000, 32'h0000_0000, 1'b1, '{ST_OK, 1'b0, 32'h0, 5'd0, 1'b1}}
    };

    // Stimulus and end of run.
    initial
    begin : stimulus
        logic [KEY_BITS-1:0] key_pool [8];
        logic [KEY_BITS-1:0] k;
        op_t                 op;
        int                  n;
        int                  j;
        int                  roll;
        int                  ins_lim;
        int                  look_lim;
        int                  rem_lim;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_steps[i])
            send_item(directed_steps[i].op, directed_steps[i].key, directed_steps[i].payload,
                      directed_steps[i].typed, directed_steps[i].want);

        // Random part in blocks of 100: fill-heavy, drain-heavy and mixed blocks in turn,
        // keys mostly from a small pool so lookups and removes hit and duplicates pile up.
        for (n = 0; n < RAND_ITEMS; n++)
        begin
            burst_mode = (n >= 700 && n < 1000);
            if (n % 100 == 0)
            begin
                key_pool[0] = '0;
                key_pool[1] = '1;
                for (j = 2; j < 8; j++)
                    key_pool[j] = KEY_BITS'($urandom);
            end
            case ((n / 100) % 3)
                0:
                begin
                    ins_lim = 60; look_lim = 80; rem_lim = 98;
                end
                1:
                begin
                    ins_lim = 20; look_lim = 45; rem_lim = 99;
                end
                default:
                begin
                    ins_lim = 35; look_lim = 65; rem_lim = 96;
                end
            endcase
            roll = $urandom_range(0, 99);
            if (roll < ins_lim)
                op = OP_INSERT;
            else if (roll < look_lim)
                op = OP_LOOKUP;
            else if (roll < rem_lim)
                op = OP_REMOVE;
            else
                op = OP_CLEAR;
            if ($urandom_range(0, 3) == 0)
                k = KEY_BITS'($urandom);
            else
                k = key_pool[$urandom_range(0, 7)];
            send_item(op, k, PAYLOAD_BITS'($urandom), 1'b0, '0);
        end
        burst_mode = 1'b0;
        in_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(posedge clk);
        // Let any stray extra result show up before closing.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Ran %0d inserts (%0d rejected as full), %0d lookups, %0d removes, %0d clears",
                 op_tally[OP_INSERT], full_rejects, op_tally[OP_LOOKUP], op_tally[OP_REMOVE],
                 op_tally[OP_CLEAR]);
        $display("%0d results checked, %0d key hits, %0d mismatches",
                 results_checked, key_hits, mismatches);
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Result side: random back-pressure, and each accepted result compared with the oldest
    // expectation.
    always @(posedge clk)
    begin : result_check
        table_result_t got;
        table_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{status: status_t'(status), found: found, payload: found_payload,
                    count: entry_count, empty: is_empty};
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: result with nothing outstanding: st=%0d f=%0d pay=%h cnt=%0d",
                             $realtime, got.status, got.found, got.payload, got.count);
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.status !== want.status || got.found !== want.found ||
                    got.payload !== want.payload || got.count !== want.count ||
                    got.empty !== want.empty)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                    begin
                        $write("%0t: exp st=%0d f=%0d pay=%h cnt=%0d e=%0d",
                               $realtime, want.status, want.found, want.payload, want.count,
                               want.empty);
                        $display(", got st=%0d f=%0d pay=%h cnt=%0d e=%0d",
                                 got.status, got.found, got.payload, got.count, got.empty);
                    end
                end
            end
        end
        out_stall <= !burst_mode && ($urandom_range(0, 99) < IDLE_PCT);
    end

    // Watchdog: too long with no transaction on either channel ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            dead_cycles <= 0;
        else if (dead_cycles >= STALL_LIMIT)
        begin
            $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending_results.size());
            $display("== FAIL ==");
            $finish;
        end
        else
            dead_cycles <= dead_cycles + 1;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/stkt_pkg.sv
hdl/stkt_ram.sv
hdl/stkt_cmp.sv
hdl/sorted_key_table_unit.sv
sim/testbench.sv
